// ===== src/wcv_pkg.sv =====
`default_nettype none

package wcv_pkg;

  // Pixel and geometry widths
  localparam int PIX_W         = 8;
  localparam int DIM_W         = 9;    // row length / row count registers, input row
  localparam int OROW_W        = 8;    // output row, 0..255
  localparam int HEIGHT_MAX    = 256;
  localparam int MAX_WIDTH_DEF = 256;

  // Kernel
  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int WEIGHT_W    = 4;
  localparam int PROD_W      = 12;   // 8-bit unsigned times 4-bit signed
  localparam int SUM_W       = 16;
  localparam int PIX_MAX     = 255;
  localparam logic signed [SUM_W-1:0] SUM_PIX_MAX = SUM_W'(PIX_MAX);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TAPS * WEIGHT_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_COLS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_ROWS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WEIGHTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE   = 3'd3;

  localparam logic [DIM_W-1:0]      RST_IMG_COLS       = 9'd256;
  localparam logic [DIM_W-1:0]      RST_IMG_ROWS       = 9'd256;
  localparam logic [CFG_DATA_W-1:0] RST_KERNEL_WEIGHTS = 36'h111111111;

  // Input kind carried in tuser
  localparam logic ACT_PIXEL = 1'b0;

  // Row slots: rows rotate through three stores by row number modulo 3
  localparam int NUM_SLOTS = 3;
  typedef logic [1:0] slot_t;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  // One queued job: centre and right columns of the window, top row first
  typedef struct packed {
    pix_t [KERNEL_SIZE-1:0] mid_col;
    pix_t [KERNEL_SIZE-1:0] right_col;
    logic                   first_col;
    logic                   end_of_row;
    logic                   end_of_frame;
  } col_pair_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_t r;
    r = (s == slot_t'(NUM_SLOTS - 1)) ? slot_t'(0) : s + slot_t'(1);
    return r;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    slot_t r;
    r = (s == slot_t'(0)) ? slot_t'(NUM_SLOTS - 1) : s - slot_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/wcv_front.sv =====
`default_nettype none

module wcv_front #(
  parameter int MAX_WIDTH = wcv_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             restart,
  input  wire logic [wcv_pkg::DIM_W-1:0]        img_cols,
  input  wire logic [wcv_pkg::DIM_W-1:0]        img_rows,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_action,
  input  wire logic [wcv_pkg::PIX_W-1:0]        in_pixel,
  input  wire logic [wcv_pkg::QCNT_W-1:0]       q_count,
  output logic                                  push_valid,
  output wcv_pkg::col_pair_t                    push_entry
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int LAG_W = $clog2(MAX_WIDTH + 2);
  localparam int KS    = wcv_pkg::KERNEL_SIZE;

  // Effective geometry
  logic [CNT_W-1:0]              w_eff;
  logic [COL_W-1:0]              w_last;
  logic [wcv_pkg::DIM_W-1:0]     h_eff;
  logic [wcv_pkg::OROW_W-1:0]    h_last;

  // Position counters
  logic [COL_W-1:0]              in_col;
  logic [wcv_pkg::DIM_W-1:0]     in_row;
  wcv_pkg::slot_t                in_slot;
  logic [COL_W-1:0]              out_col;
  logic [wcv_pkg::OROW_W-1:0]    out_row;
  wcv_pkg::slot_t                out_slot;
  logic [LAG_W-1:0]              lag;     // pixels taken minus results given on pixel beats

  logic accept, in_done, take_pixel, emit_new, emit_flush, emit;
  logic out_eor, out_eof;

  logic [wcv_pkg::DIM_W-1:0]     row_pos [KS];
  wcv_pkg::slot_t                sel     [KS];
  logic [COL_W-1:0]              col_pos [2];
  logic [1:0]                    byp     [KS];

  // Row stores and their registered read data
  wcv_pkg::pix_t row_mem [wcv_pkg::NUM_SLOTS][MAX_WIDTH];
  wcv_pkg::pix_t rd      [wcv_pkg::NUM_SLOTS][2];

  // Read stage
  logic                          b_valid;
  wcv_pkg::slot_t                b_sel   [KS];
  logic [1:0]                    b_byp   [KS];
  wcv_pkg::pix_t                 b_pixel;
  logic                          b_first, b_eor, b_eof;

  // Width or height 0 acts as 1; width above the store depth and height above HEIGHT_MAX saturate
  always_comb begin
    if (img_cols == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(img_cols) > MAX_WIDTH) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(img_cols);
    end
    w_last = COL_W'(w_eff - CNT_W'(1));
    if (img_rows == '0) begin
      h_eff = wcv_pkg::DIM_W'(1);
    end else if (int'(img_rows) > wcv_pkg::HEIGHT_MAX) begin
      h_eff = wcv_pkg::DIM_W'(wcv_pkg::HEIGHT_MAX);
    end else begin
      h_eff = img_rows;
    end
    h_last = wcv_pkg::OROW_W'(h_eff - wcv_pkg::DIM_W'(1));
  end

  // Room for one more job in the queue, counting the one in the read stage
  assign in_ready = (q_count + wcv_pkg::QCNT_W'(b_valid)) <
                    wcv_pkg::QCNT_W'(wcv_pkg::QUEUE_DEPTH);

  // Classify the beat
  assign accept     = in_valid && in_ready;
  assign in_done    = (in_row == h_eff);
  assign take_pixel = accept && (in_action == wcv_pkg::ACT_PIXEL) && !in_done;
  assign emit_new   = take_pixel && (lag >= LAG_W'(w_eff) + LAG_W'(1));
  assign emit_flush = accept && in_done;
  assign emit       = emit_new || emit_flush;
  assign out_eor    = (out_col == w_last);
  assign out_eof    = out_eor && (out_row == h_last);

  // Neighbourhood rows and columns, clamped at the border
  always_comb begin
    row_pos[0] = (out_row == '0) ? wcv_pkg::DIM_W'(out_row)
                                 : wcv_pkg::DIM_W'(out_row) - wcv_pkg::DIM_W'(1);
    row_pos[1] = wcv_pkg::DIM_W'(out_row);
    row_pos[2] = (out_row == h_last) ? wcv_pkg::DIM_W'(out_row)
                                     : wcv_pkg::DIM_W'(out_row) + wcv_pkg::DIM_W'(1);
    sel[0]     = (out_row == '0) ? out_slot : wcv_pkg::slot_dec(out_slot);
    sel[1]     = out_slot;
    sel[2]     = (out_row == h_last) ? out_slot : wcv_pkg::slot_inc(out_slot);
    col_pos[0] = out_col;
    col_pos[1] = out_eor ? out_col : out_col + COL_W'(1);
    // the pixel now arriving is not in the store yet
    for (int i = 0; i < KS; i++) begin
      for (int j = 0; j < 2; j++) begin
        byp[i][j] = take_pixel && (row_pos[i] == in_row) && (col_pos[j] == in_col);
      end
    end
  end

  // Row stores: read the old contents before this beat's pixel lands
  always_ff @(posedge clk) begin
    for (int k = 0; k < wcv_pkg::NUM_SLOTS; k++) begin
      if (emit) begin
        rd[k][0] <= row_mem[k][col_pos[0]];
        rd[k][1] <= row_mem[k][col_pos[1]];
      end
      if (take_pixel && (in_slot == wcv_pkg::slot_t'(k))) begin
        row_mem[k][in_col] <= in_pixel;
      end
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      lag      <= '0;
    end else if (accept) begin
      if (take_pixel) begin
        if (in_col == w_last) begin
          in_col  <= '0;
          in_row  <= in_row + wcv_pkg::DIM_W'(1);
          in_slot <= wcv_pkg::slot_inc(in_slot);
        end else begin
          in_col  <= in_col + COL_W'(1);
        end
        if (!emit_new) begin
          lag <= lag + LAG_W'(1);
        end
      end
      if (emit) begin
        if (out_eor) begin
          out_col  <= '0;
          out_row  <= out_row + wcv_pkg::OROW_W'(1);
          out_slot <= wcv_pkg::slot_inc(out_slot);
        end else begin
          out_col  <= out_col + COL_W'(1);
        end
      end
      // last result of the frame: back to the start
      if (emit_flush && out_eof) begin
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
        lag      <= '0;
      end
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      b_sel   <= sel;
      b_byp   <= byp;
      b_pixel <= in_pixel;
      b_first <= (out_col == '0);
      b_eor   <= out_eor;
      b_eof   <= out_eof;
    end
  end

  // Route slots to window rows and fold in the bypassed pixel
  always_comb begin
    for (int i = 0; i < KS; i++) begin
      push_entry.mid_col[i]   = b_byp[i][0] ? b_pixel : rd[b_sel[i]][0];
      push_entry.right_col[i] = b_byp[i][1] ? b_pixel : rd[b_sel[i]][1];
    end
    push_entry.first_col    = b_first;
    push_entry.end_of_row   = b_eor;
    push_entry.end_of_frame = b_eof;
  end

  assign push_valid = b_valid;

endmodule

`default_nettype wire

// ===== src/wcv_queue.sv =====
`default_nettype none

module wcv_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push_valid,
  input  wire wcv_pkg::col_pair_t          push_entry,
  output logic [wcv_pkg::QCNT_W-1:0]       count,
  output logic                             pop_valid,
  output wcv_pkg::col_pair_t               pop_entry,
  input  wire logic                        pop_ready
);

  wcv_pkg::col_pair_t               slots [wcv_pkg::QUEUE_DEPTH];
  logic [wcv_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic                             pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_entry = slots[rd_ptr];

  // Pointers and fill count; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= (wr_ptr == wcv_pkg::QPTR_W'(wcv_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + wcv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wcv_pkg::QPTR_W'(wcv_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + wcv_pkg::QPTR_W'(1);
      end
      count <= count + wcv_pkg::QCNT_W'(push_valid) - wcv_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== src/wcv_back.sv =====
`default_nettype none

module wcv_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [wcv_pkg::CFG_DATA_W-1:0]     kernel_weights,
  input  wire logic                               clamp_enable,
  input  wire logic                               q_valid,
  input  wire wcv_pkg::col_pair_t                 q_entry,
  output logic                                    q_ready,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [wcv_pkg::SUM_W-1:0]        out_value,
  output logic                                    out_eor,
  output logic                                    out_eof
);

  localparam int KS = wcv_pkg::KERNEL_SIZE;

  wcv_pkg::pix_t                       window    [wcv_pkg::TAPS];
  wcv_pkg::pix_t                       prev_mid  [KS];
  logic signed [wcv_pkg::WEIGHT_W-1:0] wgt       [wcv_pkg::TAPS];
  logic signed [wcv_pkg::PROD_W-1:0]   prod_next [wcv_pkg::TAPS];
  logic signed [wcv_pkg::PROD_W-1:0]   s1_prod   [wcv_pkg::TAPS];
  logic                                s1_valid, s1_eor, s1_eof;
  logic signed [wcv_pkg::SUM_W-1:0]    sum, result;
  logic                                s2_load, pop;

  // Stage handshakes
  assign s2_load = !out_valid || out_ready;
  assign q_ready = !s1_valid || s2_load;
  assign pop     = q_valid && q_ready;

  // Window: left column is the previous centre, or the centre again at a row start
  always_comb begin
    for (int i = 0; i < KS; i++) begin
      window[KS*i]     = q_entry.first_col ? q_entry.mid_col[i] : prev_mid[i];
      window[KS*i + 1] = q_entry.mid_col[i];
      window[KS*i + 2] = q_entry.right_col[i];
    end
    for (int m = 0; m < wcv_pkg::TAPS; m++) begin
      wgt[m]       = $signed(kernel_weights[wcv_pkg::WEIGHT_W*m +: wcv_pkg::WEIGHT_W]);
      prod_next[m] = wcv_pkg::PROD_W'($signed({1'b0, window[m]}))
                   * wcv_pkg::PROD_W'(wgt[m]);
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_ready) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod <= prod_next;
      s1_eor  <= q_entry.end_of_row;
      s1_eof  <= q_entry.end_of_frame;
      for (int i = 0; i < KS; i++) begin
        prev_mid[i] <= q_entry.mid_col[i];
      end
    end
  end

  // Sum and optional clamp to the pixel range
  always_comb begin
    sum = '0;
    for (int m = 0; m < wcv_pkg::TAPS; m++) begin
      sum = sum + wcv_pkg::SUM_W'(s1_prod[m]);
    end
    result = sum;
    if (clamp_enable) begin
      if (sum[wcv_pkg::SUM_W-1]) begin
        result = '0;
      end else if (sum > wcv_pkg::SUM_PIX_MAX) begin
        result = wcv_pkg::SUM_PIX_MAX;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_value <= result;
      out_eor   <= s1_eor;
      out_eof   <= s1_eof;
    end
  end

endmodule

`default_nettype wire

// ===== src/window_convolution_3x3_core.sv =====
`default_nettype none

// Channel    Dir  Handshake                      Beat contents
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: pixel; tuser: action (1 = flush)
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: filtered_value; tlast: end_of_row;
//                                                tuser: end_of_frame
// cfg        in   cfg_we (no back-pressure)      cfg_index selects register, cfg_data value
//
// One input beat per cycle while s_axis_tready is high; at most one result per beat.
// A result released by a beat reaches the output register through the row store read,
// the queue, the product stage, then sum and clamp.
// rst clears counters and pipeline valids; row stores are not cleared.
// m_axis_tready low stalls the arithmetic only; the four-entry queue absorbs jobs and
// s_axis_tready falls once the queue plus the job in the read stage would fill it.

module window_convolution_3x3_core #(
  parameter int MAX_WIDTH = wcv_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [wcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wcv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,   // [7:0] pixel
  input  wire logic [0:0]                         s_axis_tuser,   // [0] action
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [15:0]                             m_axis_tdata,   // [15:0] filtered_value
  output logic                                    m_axis_tlast,
  output logic [0:0]                              m_axis_tuser    // [0] end_of_frame
);

  // Configuration registers
  logic [wcv_pkg::DIM_W-1:0]       img_cols;
  logic [wcv_pkg::DIM_W-1:0]       img_rows;
  logic [wcv_pkg::CFG_DATA_W-1:0]  kernel_weights;
  logic                            clamp_enable;
  logic                            restart;

  wcv_pkg::col_pair_t              push_entry, pop_entry;
  logic                            push_valid, pop_valid, pop_ready;
  logic [wcv_pkg::QCNT_W-1:0]      q_count;
  logic signed [wcv_pkg::SUM_W-1:0] out_value;

  // Geometry writes restart the frame
  assign restart = cfg_we && ((cfg_index == wcv_pkg::REG_IMG_COLS) ||
                              (cfg_index == wcv_pkg::REG_IMG_ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      img_cols       <= wcv_pkg::RST_IMG_COLS;
      img_rows       <= wcv_pkg::RST_IMG_ROWS;
      kernel_weights <= wcv_pkg::RST_KERNEL_WEIGHTS;
      clamp_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        wcv_pkg::REG_IMG_COLS:       img_cols       <= cfg_data[wcv_pkg::DIM_W-1:0];
        wcv_pkg::REG_IMG_ROWS:       img_rows       <= cfg_data[wcv_pkg::DIM_W-1:0];
        wcv_pkg::REG_KERNEL_WEIGHTS: kernel_weights <= cfg_data;
        wcv_pkg::REG_CLAMP_ENABLE:   clamp_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: classify beats, keep the row stores, gather columns
  wcv_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .img_cols     (img_cols),
    .img_rows     (img_rows),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_action    (s_axis_tuser[0]),
    .in_pixel     (s_axis_tdata),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_entry   (push_entry)
  );

  wcv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .count      (q_count),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Back: window, products, sum and clamp
  wcv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .kernel_weights (kernel_weights),
    .clamp_enable   (clamp_enable),
    .q_valid        (pop_valid),
    .q_entry        (pop_entry),
    .q_ready        (pop_ready),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_value      (out_value),
    .out_eor        (m_axis_tlast),
    .out_eof        (m_axis_tuser[0])
  );

  assign m_axis_tdata = out_value;

  // The credit check in the front must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (q_count < wcv_pkg::QCNT_W'(wcv_pkg::QUEUE_DEPTH)))
    else $error("job pushed into a full queue");

  // The last result of a frame is always the last of its row
  a_eof_is_eor: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("end of frame without end of row");

endmodule

`default_nettype wire
